@@ hdl/rhc_pkg.sv @@
// shared types and constants for the rgb/hsv converter
package rhc_pkg;

   localparam int FIELD_BITS = 16;
   localparam int LANES      = 3;

   localparam logic DIR_RGB_TO_HSV = 1'b0;
   localparam logic DIR_HSV_TO_RGB = 1'b1;

   typedef enum logic [2:0] {
      SEC_RED_YEL  = 3'd0,
      SEC_YEL_GRN  = 3'd1,
      SEC_GRN_CYN  = 3'd2,
      SEC_CYN_BLU  = 3'd3,
      SEC_BLU_MAG  = 3'd4,
      SEC_MAG_RED  = 3'd5,
      SEC_WRAP     = 3'd6
   } sector_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] comp_a_in;
      logic [FIELD_BITS-1:0] comp_b_in;
      logic [FIELD_BITS-1:0] comp_c_in;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] comp_a_out;
      logic [FIELD_BITS-1:0] comp_b_out;
      logic [FIELD_BITS-1:0] comp_c_out;
   } rsp_type;

   typedef struct packed {
      logic                  dir;
      sector_type            sector;
      logic [FIELD_BITS-1:0] val;
   } meta_type;

endpackage

@@ hdl/rhc_front.sv @@
// front end: min/max and sector decode, then dividend and divisor forming
module rhc_front #(
   parameter int W = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  rhc_pkg::req_type                       in_data,
   input  logic                                   dir,
   output logic                                   out_valid,
   output logic [rhc_pkg::LANES-1:0][3*W-1:0]     out_rem,
   output logic [rhc_pkg::LANES-1:0][2*W-1:0]     out_den,
   output rhc_pkg::meta_type                      out_meta
);

   localparam int NW = 3 * W;
   localparam int DW = 2 * W;
   localparam int NB = W + 3;
   localparam logic [W-1:0]  FS_W = {W{1'b1}};
   localparam logic [DW-1:0] FS_D = DW'(FS_W);
   localparam logic [DW-1:0] FS2  = FS_D * FS_D;

   logic [W-1:0]  a, b, c, mx, mn, d;
   logic [NB-1:0] n, x, fr_sum;
   logic [2:0]    qh, sect;
   logic [W-1:0]  fr;

   logic                 s1_valid_ff;
   logic                 s1_dir_ff;
   logic [2:0]           s1_sect_ff;
   logic [W-1:0]         s1_v_ff, s1_d_ff, s1_mx_ff;
   logic [NB-1:0]        s1_n_ff;
   logic [DW-1:0]        s1_sfr_ff, s1_sfc_ff, s1_pnum_ff;

   logic                                 s2_valid_ff;
   logic [rhc_pkg::LANES-1:0][NW-1:0]    s2_rem_ff, s2_rem_in;
   logic [rhc_pkg::LANES-1:0][DW-1:0]    s2_den_ff, s2_den_in;
   rhc_pkg::meta_type                    s2_meta_ff, s2_meta_in;

   always_comb begin
      a = in_data.comp_a_in[W-1:0];
      b = in_data.comp_b_in[W-1:0];
      c = in_data.comp_c_in[W-1:0];
      mx = a;
      if (b > mx) mx = b;
      if (c > mx) mx = c;
      mn = a;
      if (b < mn) mn = b;
      if (c < mn) mn = c;
      d = mx - mn;
      if (mx == a) begin
         if (b >= c) n = NB'(b) - NB'(c);
         else n = (NB'(d) << 2) + (NB'(d) << 1) - (NB'(c) - NB'(b));
      end else if (mx == b) begin
         n = (NB'(d) << 1) + NB'(c) - NB'(a);
      end else begin
         n = (NB'(d) << 2) + NB'(a) - NB'(b);
      end
      x = (NB'(a) << 2) + (NB'(a) << 1);
      qh = x[NB-1:W];
      fr_sum = NB'(x[W-1:0]) + NB'(qh);
      if (fr_sum >= NB'(FS_W)) begin
         sect = qh + 3'd1;
         fr   = W'(fr_sum - NB'(FS_W));
      end else begin
         sect = qh;
         fr   = W'(fr_sum);
      end
      if (sect == 3'(rhc_pkg::SEC_WRAP)) sect = 3'(rhc_pkg::SEC_RED_YEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dir_ff  <= dir;
         s1_sect_ff <= sect;
         s1_v_ff    <= c;
         s1_d_ff    <= d;
         s1_mx_ff   <= mx;
         s1_n_ff    <= n;
         s1_sfr_ff  <= DW'(b) * DW'(fr);
         s1_sfc_ff  <= DW'(b) * DW'(FS_W - fr);
         s1_pnum_ff <= DW'(c) * DW'(FS_W - b);
         s2_rem_ff  <= s2_rem_in;
         s2_den_ff  <= s2_den_in;
         s2_meta_ff <= s2_meta_in;
      end
   end

   always_comb begin
      s2_meta_in.dir    = s1_dir_ff;
      s2_meta_in.sector = rhc_pkg::sector_type'(s1_sect_ff);
      s2_meta_in.val    = rhc_pkg::FIELD_BITS'(s1_v_ff);
      if (s1_dir_ff == rhc_pkg::DIR_RGB_TO_HSV) begin
         if (s1_d_ff == '0) begin
            s2_rem_in[0] = '0;
            s2_den_in[0] = DW'(1);
         end else begin
            s2_rem_in[0] = (NW'(s1_n_ff) << W) - NW'(s1_n_ff);
            s2_den_in[0] = (DW'(s1_d_ff) << 2) + (DW'(s1_d_ff) << 1);
         end
         if (s1_mx_ff == '0) begin
            s2_rem_in[1] = '0;
            s2_den_in[1] = DW'(1);
         end else begin
            s2_rem_in[1] = (NW'(s1_d_ff) << W) - NW'(s1_d_ff);
            s2_den_in[1] = DW'(s1_mx_ff);
         end
         s2_rem_in[2] = NW'(s1_mx_ff);
         s2_den_in[2] = DW'(1);
      end else begin
         s2_rem_in[0] = NW'(s1_pnum_ff);
         s2_den_in[0] = FS_D;
         s2_rem_in[1] = NW'(s1_v_ff) * NW'(FS2 - s1_sfr_ff);
         s2_den_in[1] = FS2;
         s2_rem_in[2] = NW'(s1_v_ff) * NW'(FS2 - s1_sfc_ff);
         s2_den_in[2] = FS2;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_rem   = s2_rem_ff;
   assign out_den   = s2_den_ff;
   assign out_meta  = s2_meta_ff;

endmodule

@@ hdl/rhc_div_cell.sv @@
// one quotient bit of three restoring dividers, registered
module rhc_div_cell #(
   parameter int W   = 16,
   parameter int BIT = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [rhc_pkg::LANES-1:0][3*W-1:0]     in_rem,
   input  logic [rhc_pkg::LANES-1:0][2*W-1:0]     in_den,
   input  logic [rhc_pkg::LANES-1:0][W-1:0]       in_quo,
   input  rhc_pkg::meta_type                      in_meta,
   output logic                                   out_valid,
   output logic [rhc_pkg::LANES-1:0][3*W-1:0]     out_rem,
   output logic [rhc_pkg::LANES-1:0][2*W-1:0]     out_den,
   output logic [rhc_pkg::LANES-1:0][W-1:0]       out_quo,
   output rhc_pkg::meta_type                      out_meta
);

   localparam int NW = 3 * W;

   logic [rhc_pkg::LANES-1:0][NW-1:0] sub;
   logic [rhc_pkg::LANES-1:0][NW-1:0] rem_in, rem_ff;
   logic [rhc_pkg::LANES-1:0][W-1:0]  quo_in, quo_ff;
   logic [rhc_pkg::LANES-1:0][2*W-1:0] den_ff;
   rhc_pkg::meta_type                 meta_ff;
   logic                              valid_ff;

   always_comb begin
      for (int l = 0; l < rhc_pkg::LANES; l++) begin
         sub[l] = NW'(in_den[l]) << BIT;
         if (in_rem[l] >= sub[l]) begin
            rem_in[l] = in_rem[l] - sub[l];
            quo_in[l] = in_quo[l] | (W'(1) << BIT);
         end else begin
            rem_in[l] = in_rem[l];
            quo_in[l] = in_quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= in_den;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_meta  = meta_ff;

endmodule

@@ hdl/rgb_hsv_converter.sv @@
// rgb/hsv pixel converter top level
//
// req_valid/req_ready/req_data take one pixel word per cycle: three
// components of COMPONENT_BITS bits each (upper bits of the 16-bit fields
// are ignored). rsp_valid/rsp_ready/rsp_data return one converted word per
// pixel, in order. csr_valid/csr_ready/csr_data writes the direction bit
// (0 rgb to hsv, 1 hsv to rgb); write it only while the pipe is empty.
// The pipe has two front-end stages, one divider cell per quotient bit,
// and the output register. Throughput is one word per cycle; every
// stage moves together, and an empty output register keeps the pipe
// moving even while rsp_ready is low.
// When rsp_ready is low with a word held, the whole pipe freezes and
// req_ready drops. Reset empties the pipe and sets direction to 0.
module rgb_hsv_converter #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rhc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rhc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int W  = COMPONENT_BITS;
   localparam int NW = 3 * W;
   localparam int DW = 2 * W;

   logic direction_ff;
   logic advance;

   logic [W:0]                                  v_w;
   logic [W:0][rhc_pkg::LANES-1:0][NW-1:0]      rem_w;
   logic [W:0][rhc_pkg::LANES-1:0][DW-1:0]      den_w;
   logic [W:0][rhc_pkg::LANES-1:0][W-1:0]       quo_w;
   rhc_pkg::meta_type [W:0]                     meta_w;

   logic             rsp_valid_ff;
   rhc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [W-1:0]     qa, qb, qc, vv;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= rhc_pkg::DIR_RGB_TO_HSV;
      end else if (csr_valid) begin
         direction_ff <= csr_data;
      end
   end

   rhc_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .dir       (direction_ff),
      .out_valid (v_w[0]),
      .out_rem   (rem_w[0]),
      .out_den   (den_w[0]),
      .out_meta  (meta_w[0])
   );

   assign quo_w[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_cell
      rhc_div_cell #(.W(W), .BIT(W - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_valid  (v_w[k]),
         .in_rem    (rem_w[k]),
         .in_den    (den_w[k]),
         .in_quo    (quo_w[k]),
         .in_meta   (meta_w[k]),
         .out_valid (v_w[k+1]),
         .out_rem   (rem_w[k+1]),
         .out_den   (den_w[k+1]),
         .out_quo   (quo_w[k+1]),
         .out_meta  (meta_w[k+1])
      );
   end

   always_comb begin
      qa = quo_w[W][0];
      qb = quo_w[W][1];
      qc = quo_w[W][2];
      vv = meta_w[W].val[W-1:0];
      if (meta_w[W].dir == rhc_pkg::DIR_RGB_TO_HSV) begin
         rsp_data_in.comp_a_out = rhc_pkg::FIELD_BITS'(qa);
         rsp_data_in.comp_b_out = rhc_pkg::FIELD_BITS'(qb);
         rsp_data_in.comp_c_out = rhc_pkg::FIELD_BITS'(qc);
      end else begin
         // lanes carry p, q, t
         case (meta_w[W].sector)
            rhc_pkg::SEC_RED_YEL: begin
               rsp_data_in.comp_a_out = rhc_pkg::FIELD_BITS'(vv);
               rsp_data_in.comp_b_out = rhc_pkg::FIELD_BITS'(qc);
               rsp_data_in.comp_c_out = rhc_pkg::FIELD_BITS'(qa);
            end
            rhc_pkg::SEC_YEL_GRN: begin
               rsp_data_in.comp_a_out = rhc_pkg::FIELD_BITS'(qb);
               rsp_data_in.comp_b_out = rhc_pkg::FIELD_BITS'(vv);
               rsp_data_in.comp_c_out = rhc_pkg::FIELD_BITS'(qa);
            end
            rhc_pkg::SEC_GRN_CYN: begin
               rsp_data_in.comp_a_out = rhc_pkg::FIELD_BITS'(qa);
               rsp_data_in.comp_b_out = rhc_pkg::FIELD_BITS'(vv);
               rsp_data_in.comp_c_out = rhc_pkg::FIELD_BITS'(qc);
            end
            rhc_pkg::SEC_CYN_BLU: begin
               rsp_data_in.comp_a_out = rhc_pkg::FIELD_BITS'(qa);
               rsp_data_in.comp_b_out = rhc_pkg::FIELD_BITS'(qb);
               rsp_data_in.comp_c_out = rhc_pkg::FIELD_BITS'(vv);
            end
            rhc_pkg::SEC_BLU_MAG: begin
               rsp_data_in.comp_a_out = rhc_pkg::FIELD_BITS'(qc);
               rsp_data_in.comp_b_out = rhc_pkg::FIELD_BITS'(qa);
               rsp_data_in.comp_c_out = rhc_pkg::FIELD_BITS'(vv);
            end
            default: begin
               rsp_data_in.comp_a_out = rhc_pkg::FIELD_BITS'(vv);
               rsp_data_in.comp_b_out = rhc_pkg::FIELD_BITS'(qa);
               rsp_data_in.comp_c_out = rhc_pkg::FIELD_BITS'(qb);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v_w[W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/sv/tb_rgb_hsv_converter.sv @@
// self-checking testbench for the rgb/hsv pixel converter
`timescale 1ns / 1ps
module tb_rgb_hsv_converter;

   localparam longint FS    = 65535;
   localparam int     DRAIN = 40;
   localparam logic   TO_HSV = rhc_pkg::DIR_RGB_TO_HSV;
   localparam logic   TO_RGB = rhc_pkg::DIR_HSV_TO_RGB;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   rhc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rhc_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_data = 1'b0;

   logic             cur_dir = TO_HSV;
   int               send_idle = 0;
   int               recv_stall = 0;
   int               errors = 0;
   int               pixels_sent = 0;
   int               pixels_checked = 0;
   rhc_pkg::rsp_type pixel_queue[$];

   rgb_hsv_converter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clamp_fs(longint x);
      return (x > FS) ? FS : x;
   endfunction

   function automatic rhc_pkg::rsp_type convert_pixel(logic dir, rhc_pkg::req_type px);
      longint  r, g, b, mx, mn, d, n, hue, sat, x, fr, p, q, t;
      longint  fs2;
      int      sec;
      rhc_pkg::rsp_type o;
      fs2 = FS * FS;
      if (dir == TO_HSV) begin
         r = px.comp_a_in; g = px.comp_b_in; b = px.comp_c_in;
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d = mx - mn;
         sat = (mx > 0) ? (d * FS) / mx : 0;
         hue = 0;
         if (d > 0) begin
            if (mx == r) n = (g >= b) ? (g - b) : (6 * d - (b - g));
            else if (mx == g) n = 2 * d + b - r;
            else n = 4 * d + r - g;
            hue = (n * FS) / (6 * d);
         end
         o.comp_a_out = hue[15:0];
         o.comp_b_out = sat[15:0];
         o.comp_c_out = mx[15:0];
      end else begin
         x = longint'(px.comp_a_in) * 6;
         sec = int'((x / FS) % 6);
         fr = x % FS;
         p = clamp_fs((px.comp_c_in * (FS - px.comp_b_in)) / FS);
         q = clamp_fs((px.comp_c_in * (fs2 - px.comp_b_in * fr)) / fs2);
         t = clamp_fs((px.comp_c_in * (fs2 - px.comp_b_in * (FS - fr))) / fs2);
         case (rhc_pkg::sector_type'(sec))
            rhc_pkg::SEC_RED_YEL: o = {px.comp_c_in, t[15:0], p[15:0]};
            rhc_pkg::SEC_YEL_GRN: o = {q[15:0], px.comp_c_in, p[15:0]};
            rhc_pkg::SEC_GRN_CYN: o = {p[15:0], px.comp_c_in, t[15:0]};
            rhc_pkg::SEC_CYN_BLU: o = {p[15:0], q[15:0], px.comp_c_in};
            rhc_pkg::SEC_BLU_MAG: o = {t[15:0], p[15:0], px.comp_c_in};
            default:              o = {px.comp_c_in, p[15:0], q[15:0]};
         endcase
      end
      return o;
   endfunction

   task automatic write_direction(logic dir);
      csr_valid <= 1'b1;
      csr_data  <= dir;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_dir = dir;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic send_pixel(rhc_pkg::req_type px, bit use_fixed, rhc_pkg::rsp_type fixed);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      pixel_queue.push_back(use_fixed ? fixed : convert_pixel(cur_dir, px));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            if (rsp_data !== pixel_queue[0]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h actual %h", pixel_queue[0], rsp_data);
            end
            void'(pixel_queue.pop_front());
            pixels_checked++;
         end
      end
      rsp_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
   end

   typedef struct {
      logic             dir;
      rhc_pkg::req_type px;
      bit               fixed_ok;
      rhc_pkg::rsp_type want;
   } dir_row_type;

   dir_row_type directed[] = '{
      '{TO_HSV, '{16'h0000, 16'h0000, 16'h0000}, 1, '{16'h0000, 16'h0000, 16'h0000}},
      '{TO_HSV, '{16'hffff, 16'hffff, 16'hffff}, 1, '{16'h0000, 16'h0000, 16'hffff}},
      '{TO_HSV, '{16'h8000, 16'h8000, 16'h8000}, 1, '{16'h0000, 16'h0000, 16'h8000}},
      '{TO_HSV, '{16'hffff, 16'h0000, 16'h0000}, 1, '{16'h0000, 16'hffff, 16'hffff}},
      '{TO_HSV, '{16'h0000, 16'hffff, 16'h0000}, 0, '0},
      '{TO_HSV, '{16'h0000, 16'h0000, 16'hffff}, 0, '0},
      '{TO_HSV, '{16'hffff, 16'hffff, 16'h0000}, 0, '0},
      '{TO_HSV, '{16'h0000, 16'hffff, 16'hffff}, 0, '0},
      '{TO_HSV, '{16'hffff, 16'h0000, 16'hffff}, 0, '0},
      '{TO_HSV, '{16'hffff, 16'h0000, 16'h0001}, 0, '0},
      '{TO_HSV, '{16'h1234, 16'h1234, 16'h0001}, 0, '0},
      '{TO_HSV, '{16'h0001, 16'h0000, 16'h0000}, 0, '0},
      '{TO_RGB, '{16'h0000, 16'h0000, 16'h0000}, 1, '{16'h0000, 16'h0000, 16'h0000}},
      '{TO_RGB, '{16'h0000, 16'h0000, 16'hffff}, 1, '{16'hffff, 16'hffff, 16'hffff}},
      '{TO_RGB, '{16'h0000, 16'hffff, 16'hffff}, 1, '{16'hffff, 16'h0000, 16'h0000}},
      '{TO_RGB, '{16'hffff, 16'hffff, 16'hffff}, 1, '{16'hffff, 16'h0000, 16'h0000}},
      '{TO_RGB, '{16'hfffe, 16'hffff, 16'hffff}, 0, '0},
      '{TO_RGB, '{16'h2aaa, 16'hffff, 16'hffff}, 0, '0},
      '{TO_RGB, '{16'h5555, 16'h8000, 16'hc000}, 0, '0},
      '{TO_RGB, '{16'h8000, 16'hffff, 16'h7fff}, 0, '0},
      '{TO_RGB, '{16'haaaa, 16'h1234, 16'hffff}, 0, '0},
      '{TO_RGB, '{16'hd555, 16'hffff, 16'h0001}, 0, '0}
   };

   function automatic rhc_pkg::req_type random_pixel();
      rhc_pkg::req_type px;
      case ($urandom_range(3))
         0: px = '{16'($urandom), 16'($urandom), 16'($urandom)};
         1: px = '{16'($urandom_range(1) * 16'hffff), 16'($urandom),
                   16'($urandom_range(1) * 16'hffff)};
         2: begin
            px.comp_a_in = 16'($urandom);
            px.comp_b_in = ($urandom_range(1) != 0) ? px.comp_a_in : 16'($urandom);
            px.comp_c_in = ($urandom_range(1) != 0) ? px.comp_b_in : 16'($urandom);
         end
         default: px = '{16'($urandom_range(15)), 16'($urandom_range(15)),
                         16'($urandom_range(15))};
      endcase
      return px;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].dir != cur_dir) begin
            wait_drained();
            write_direction(directed[i].dir);
         end
         send_pixel(directed[i].px, directed[i].fixed_ok, directed[i].want);
      end
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 55; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 55; end
            default: begin send_idle = 33; recv_stall = 33; end
         endcase
         wait_drained();
         write_direction(phase[0] ? TO_HSV : TO_RGB);
         for (int k = 0; k < 50; k++) send_pixel(random_pixel(), 0, '0);
      end
      wait_drained();
      $display("sent %0d pixels, checked %0d words, both directions, four idle patterns",
               pixels_sent, pixels_checked);
      if (errors == 0 && pixel_queue.size() == 0) begin
         $display("tb_rgb_hsv_converter OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("tb_rgb_hsv_converter NOT OK");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("tb_rgb_hsv_converter NOT OK");
      $finish;
   end
endmodule
